// ===== design/assert_macros.svh =====
// assertion macros used by the axis core design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under a synchronous reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication under a synchronous reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/qlm_pkg.sv =====
// types and constants of the queued linear move axis
package qlm_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int POS_W       = 32;
   localparam int TIME_W      = 16;
   localparam int TL_W        = 18;
   localparam int MAG_W       = 32;
   localparam int PROD_W      = MAG_W + TIME_W;
   localparam int SUM_W       = PROD_W + 2;
   localparam int TASK_W      = POS_W + TIME_W;

   localparam int DIGIT_W     = 2;
   localparam int STEP_CYCLES = MAG_W / DIGIT_W;
   localparam int STEP_CNT_W  = $clog2(STEP_CYCLES);

   localparam int REQ_DATA_W  = 64;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 72;

   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   typedef enum logic [1:0] {
      FUNC_ENQUEUE = 2'd0,
      FUNC_TICK    = 2'd1,
      FUNC_ENABLE  = 2'd2,
      FUNC_DISABLE = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL,
      ST_APPLY,
      ST_CHECK,
      ST_READ,
      ST_SIGN,
      ST_DIV,
      ST_FINISH
   } state_type;

endpackage

// ===== design/qlm_ram.sv =====
// generic single-port-write ram with registered read
module qlm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/qlm_mul.sv =====
// shift-add multiplier, rate magnitude by delta time, two bits per cycle
module qlm_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [qlm_pkg::TIME_W-1:0]      mcand,
   input  logic [qlm_pkg::MAG_W-1:0]       mplier,
   output logic                            done,
   output logic [qlm_pkg::PROD_W-1:0]      product
);

   localparam logic [qlm_pkg::STEP_CNT_W-1:0] LAST =
      qlm_pkg::STEP_CNT_W'(qlm_pkg::STEP_CYCLES - 1);

   logic [qlm_pkg::PROD_W-1:0]     acc_ff, acc_in;
   logic [qlm_pkg::TIME_W-1:0]     mcand_ff;
   logic [qlm_pkg::STEP_CNT_W-1:0] cnt_ff;
   logic                           busy_ff;
   logic                           done_ff;

   always_comb begin
      logic [qlm_pkg::TIME_W:0] hi;
      acc_in = acc_ff;
      for (int i = 0; i < qlm_pkg::DIGIT_W; i++) begin
         hi = {1'b0, acc_in[qlm_pkg::PROD_W-1:qlm_pkg::MAG_W]};
         if (acc_in[0]) begin
            hi = hi + {1'b0, mcand_ff};
         end
         acc_in = {hi, acc_in[qlm_pkg::MAG_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == LAST);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff   <= {{qlm_pkg::TIME_W{1'b0}}, mplier};
         mcand_ff <= mcand;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== design/qlm_div.sv =====
// restoring divider, distance magnitude by duration, two quotient bits per cycle
module qlm_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [qlm_pkg::MAG_W-1:0]       dividend,
   input  logic [qlm_pkg::TIME_W-1:0]      divisor,
   output logic                            done,
   output logic [qlm_pkg::MAG_W-1:0]       quotient
);

   localparam logic [qlm_pkg::STEP_CNT_W-1:0] LAST =
      qlm_pkg::STEP_CNT_W'(qlm_pkg::STEP_CYCLES - 1);

   logic [qlm_pkg::TIME_W-1:0]     rem_ff, rem_in;
   logic [qlm_pkg::MAG_W-1:0]      quo_ff, quo_in;
   logic [qlm_pkg::TIME_W-1:0]     dsr_ff;
   logic [qlm_pkg::STEP_CNT_W-1:0] cnt_ff;
   logic                           busy_ff;
   logic                           done_ff;

   always_comb begin
      logic [qlm_pkg::TIME_W:0] trial;
      rem_in = rem_ff;
      quo_in = quo_ff;
      for (int i = 0; i < qlm_pkg::DIGIT_W; i++) begin
         trial = {rem_in, quo_in[qlm_pkg::MAG_W-1]};
         if (trial >= {1'b0, dsr_ff}) begin
            trial  = trial - {1'b0, dsr_ff};
            quo_in = {quo_in[qlm_pkg::MAG_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_in[qlm_pkg::MAG_W-2:0], 1'b0};
         end
         rem_in = trial[qlm_pkg::TIME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == LAST);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== design/queued_linear_move_axis_core.sv =====
// top level of the queued linear move axis: task fifo, sequencer and result register
// One Q16.16 axis follows a fifo of (destination, duration) moves held in a small ram.
// A beat is taken whenever the sequencer is idle, also while the last result beat
// still waits at the output register. Enqueue, enable and disable beats go from
// decode to finish; a tick on a moving axis waits on the multiplier and applies the
// step; a tick that also loads the next task then reads the ram and waits on the
// divider. The fifo needs no clearing pass after reset.
`include "assert_macros.svh"

module queued_linear_move_axis_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // destination[31:0], duration[47:32], delta_time[63:48]
   input  logic [qlm_pkg::REQ_DATA_W-1:0]   req_tdata,
   // func[1:0]
   input  logic [qlm_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // position[31:0], ready_res[32], enabled[33], queue_empty[34], task_dropped[35],
   // last_queued_destination[67:36], zero[71:68]
   output logic [qlm_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int P = qlm_pkg::POS_W;
   localparam int T = qlm_pkg::TIME_W;

   qlm_pkg::state_type             state_ff, state_in;
   logic [qlm_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [qlm_pkg::IDX_W-1:0]      head_ff, head_in;
   logic [qlm_pkg::IDX_W-1:0]      tail_ff, tail_in;
   logic signed [P-1:0]            pos_ff, pos_in;
   logic                           rate_neg_ff, rate_neg_in;
   logic [qlm_pkg::MAG_W-1:0]      rate_mag_ff, rate_mag_in;
   logic signed [qlm_pkg::TL_W-1:0] tl_ff, tl_in;
   logic signed [P-1:0]            target_ff, target_in;
   logic                           idle_ff, idle_in;
   logic                           enable_ff, enable_in;
   logic                           dropped_ff, dropped_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   qlm_pkg::func_type              func_ff;
   logic signed [P-1:0]            dest_ff;
   logic [T-1:0]                   dur_ff;
   logic [T-1:0]                   dt_ff;
   logic signed [P:0]              diff_ff, diff_in;
   logic [T-1:0]                   dur_ld_ff, dur_ld_in;
   logic signed [P-1:0]            last_dest_ff, last_dest_in;
   logic [qlm_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                           mul_start, mul_done;
   logic [qlm_pkg::PROD_W-1:0]     mul_product;
   logic                           div_start, div_done;
   logic [qlm_pkg::MAG_W-1:0]      div_quotient;
   logic [qlm_pkg::MAG_W-1:0]      diff_mag;

   logic                           ram_we, ram_re;
   logic [qlm_pkg::TASK_W-1:0]     ram_rd_data;

   logic signed [qlm_pkg::SUM_W-1:0] pos_ext, prod_ext, mov_sum;
   logic signed [qlm_pkg::TL_W-1:0]  tl_next;
   logic signed [P-1:0]              pos_sat;
   logic                             req_take;
   logic                             fifo_full;
   logic [qlm_pkg::IDX_W-1:0]        head_next, tail_next;

   qlm_ram #(
      .WIDTH (qlm_pkg::TASK_W),
      .DEPTH (qlm_pkg::QUEUE_DEPTH)
   ) u_task_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data ({dur_ff, dest_ff}),
      .rd_en   (ram_re),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   qlm_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (dt_ff),
      .mplier  (rate_mag_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   qlm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff_mag),
      .divisor  (dur_ld_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_tready = (state_ff == qlm_pkg::ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign fifo_full  = (count_ff == qlm_pkg::CNT_W'(qlm_pkg::QUEUE_DEPTH));
   assign head_next  = (head_ff == qlm_pkg::IDX_W'(qlm_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : head_ff + 1'b1;
   assign tail_next  = (tail_ff == qlm_pkg::IDX_W'(qlm_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : tail_ff + 1'b1;

   // advance of a move in progress, saturated to the position range
   assign pos_ext  = qlm_pkg::SUM_W'(pos_ff);
   assign prod_ext = $signed({2'b00, mul_product});
   assign mov_sum  = rate_neg_ff ? pos_ext - prod_ext : pos_ext + prod_ext;
   assign pos_sat  = (mov_sum[qlm_pkg::SUM_W-1:P-1] !=
                      {(qlm_pkg::SUM_W-P+1){mov_sum[qlm_pkg::SUM_W-1]}}) ?
                     (mov_sum[qlm_pkg::SUM_W-1] ? qlm_pkg::POS_MIN : qlm_pkg::POS_MAX) :
                     mov_sum[P-1:0];
   assign tl_next  = tl_ff - $signed({2'b00, dt_ff});
   assign diff_mag = diff_ff[P] ? qlm_pkg::MAG_W'(-diff_ff) : qlm_pkg::MAG_W'(diff_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      pos_in       = pos_ff;
      rate_neg_in  = rate_neg_ff;
      rate_mag_in  = rate_mag_ff;
      tl_in        = tl_ff;
      target_in    = target_ff;
      idle_in      = idle_ff;
      enable_in    = enable_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff;
      diff_in      = diff_ff;
      dur_ld_in    = dur_ld_ff;
      last_dest_in = last_dest_ff;
      rsp_data_in  = rsp_data_ff;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         qlm_pkg::ST_IDLE: begin
            if (req_take) begin
               dropped_in = 1'b0;
               state_in   = qlm_pkg::ST_DECODE;
            end
         end
         qlm_pkg::ST_DECODE: begin
            unique case (func_ff)
               qlm_pkg::FUNC_ENQUEUE: begin
                  if (fifo_full) begin
                     dropped_in = 1'b1;
                  end else begin
                     ram_we       = 1'b1;
                     tail_in      = tail_next;
                     count_in     = count_ff + 1'b1;
                     last_dest_in = dest_ff;
                  end
                  state_in = qlm_pkg::ST_FINISH;
               end
               qlm_pkg::FUNC_TICK: begin
                  if (!enable_ff) begin
                     state_in = qlm_pkg::ST_FINISH;
                  end else if (!idle_ff) begin
                     mul_start = 1'b1;
                     state_in  = qlm_pkg::ST_MUL;
                  end else begin
                     state_in = qlm_pkg::ST_CHECK;
                  end
               end
               qlm_pkg::FUNC_ENABLE: begin
                  enable_in = 1'b1;
                  state_in  = qlm_pkg::ST_FINISH;
               end
               qlm_pkg::FUNC_DISABLE: begin
                  enable_in = 1'b0;
                  state_in  = qlm_pkg::ST_FINISH;
               end
               default: begin
                  state_in = qlm_pkg::ST_FINISH;
               end
            endcase
         end
         qlm_pkg::ST_MUL: begin
            if (mul_done) begin
               state_in = qlm_pkg::ST_APPLY;
            end
         end
         qlm_pkg::ST_APPLY: begin
            tl_in = tl_next;
            if (tl_next[qlm_pkg::TL_W-1] || (tl_next == '0)) begin
               pos_in  = target_ff;
               idle_in = 1'b1;
            end else begin
               pos_in = pos_sat;
            end
            state_in = qlm_pkg::ST_CHECK;
         end
         qlm_pkg::ST_CHECK: begin
            if (idle_ff && (count_ff != '0)) begin
               ram_re   = 1'b1;
               state_in = qlm_pkg::ST_READ;
            end else begin
               if (idle_ff) begin
                  enable_in = 1'b0;
               end
               state_in = qlm_pkg::ST_FINISH;
            end
         end
         qlm_pkg::ST_READ: begin
            diff_in   = {ram_rd_data[P-1], ram_rd_data[P-1:0]} - {pos_ff[P-1], pos_ff};
            target_in = ram_rd_data[P-1:0];
            dur_ld_in = ram_rd_data[qlm_pkg::TASK_W-1:P];
            tl_in     = $signed({2'b00, ram_rd_data[qlm_pkg::TASK_W-1:P]});
            head_in   = head_next;
            count_in  = count_ff - 1'b1;
            idle_in   = 1'b0;
            state_in  = qlm_pkg::ST_SIGN;
         end
         qlm_pkg::ST_SIGN: begin
            div_start   = 1'b1;
            rate_neg_in = diff_ff[P];
            state_in    = qlm_pkg::ST_DIV;
         end
         qlm_pkg::ST_DIV: begin
            if (div_done) begin
               rate_mag_in = (dur_ld_ff == '0) ? '0 : div_quotient;
               state_in    = qlm_pkg::ST_FINISH;
            end
         end
         qlm_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000,
                               (count_ff == '0) ? {P{1'b0}} : last_dest_ff,
                               dropped_ff, (count_ff == '0), enable_ff, idle_ff,
                               pos_ff};
               state_in     = qlm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = qlm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qlm_pkg::ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         pos_ff       <= '0;
         rate_neg_ff  <= 1'b0;
         rate_mag_ff  <= '0;
         tl_ff        <= '0;
         target_ff    <= '0;
         idle_ff      <= 1'b1;
         enable_ff    <= 1'b1;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         pos_ff       <= pos_in;
         rate_neg_ff  <= rate_neg_in;
         rate_mag_ff  <= rate_mag_in;
         tl_ff        <= tl_in;
         target_ff    <= target_in;
         idle_ff      <= idle_in;
         enable_ff    <= enable_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request beat capture and datapath payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff <= qlm_pkg::func_type'(req_tuser);
         dest_ff <= req_tdata[P-1:0];
         dur_ff  <= req_tdata[P+T-1:P];
         dt_ff   <= req_tdata[P+2*T-1:P+T];
      end
      diff_ff      <= diff_in;
      dur_ld_ff    <= dur_ld_in;
      last_dest_ff <= last_dest_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= qlm_pkg::CNT_W'(qlm_pkg::QUEUE_DEPTH), "fifo count beyond depth")
   `ASSERT_IMPLIES(a_empty_ptrs, clock, reset, count_ff == '0, head_ff == tail_ff, "empty fifo with unequal pointers")
   `ASSERT_IMPLIES(a_mul_done_state, clock, reset, mul_done, state_ff == qlm_pkg::ST_MUL, "multiplier finished outside its wait state")
   `ASSERT_IMPLIES(a_div_done_state, clock, reset, div_done, state_ff == qlm_pkg::ST_DIV, "divider finished outside its wait state")
   `ASSERT_NEXT(a_rsp_from_finish, clock, reset, state_ff != qlm_pkg::ST_FINISH && !rsp_valid_ff, !rsp_valid_ff, "result beat raised outside finish")

endmodule
